/* rtl/tci_pkg.sv */
package tci_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // queue depths: decoupling queue and result queue
  localparam int MQ_DEPTH = 2;
  localparam int OQ_DEPTH = 8;

  // config bus
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

endpackage

/* rtl/tci_fifo.sv */
module tci_fifo import tci_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

/* rtl/tci_front.sv */
module tci_front import tci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int D  = COORD_BITS + 1,
  localparam int EW = 12 * D + COORD_BITS - 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [COORD_BITS-2:0] radius,
  input  logic                         push,
  output logic                         full,
  input  logic                         mq_pop,
  output logic [EW-1:0]                mq_data,
  output logic                         mq_empty
);

  logic signed [D-1:0] sx [3];
  logic signed [D-1:0] sy [3];
  logic signed [D-1:0] ex [3];
  logic signed [D-1:0] ey [3];
  logic [EW-1:0]       entry;

  // edge k runs from vertex k to vertex k+1
  always_comb begin
    sx[0] = D'(ax); sy[0] = D'(ay); ex[0] = D'(bx); ey[0] = D'(by);
    sx[1] = D'(bx); sy[1] = D'(by); ex[1] = D'(cx); ey[1] = D'(cy);
    sx[2] = D'(cx); sy[2] = D'(cy); ex[2] = D'(ax); ey[2] = D'(ay);
    entry = '0;
    for (int k = 0; k < 3; k++) begin
      entry[k*4*D       +: D] = D'(center_x) - sx[k];
      entry[k*4*D + D   +: D] = D'(center_y) - sy[k];
      entry[k*4*D + 2*D +: D] = ex[k] - sx[k];
      entry[k*4*D + 3*D +: D] = ey[k] - sy[k];
    end
    entry[12*D +: COORD_BITS-1] = radius;
  end

  tci_fifo #(.WIDTH(EW), .DEPTH(MQ_DEPTH)) u_mq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (mq_pop),
    .rdata (mq_data),
    .full  (full),
    .empty (mq_empty)
  );

endmodule

/* rtl/tci_back.sv */
module tci_back import tci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int D  = COORD_BITS + 1,
  localparam int EW = 12 * D + COORD_BITS - 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          mq_empty,
  input  logic [EW-1:0] mq_data,
  output logic          mq_pop,
  input  logic          oq_pop,
  output logic          oq_push,
  output logic [1:0]    oq_data
);

  localparam int PW  = 2 * COORD_BITS + 2;
  localparam int SW  = PW + 1;
  localparam int H   = D;
  localparam int R2W = 2 * COORD_BITS - 2;
  localparam int XW  = 2 * PW;
  localparam int UW  = $clog2(OQ_DEPTH + 1);

  // credit: items taken from the decoupling queue and not yet popped
  logic [UW-1:0] used;
  logic [UW-1:0] used_next;

  logic signed [D-1:0] qx [3];
  logic signed [D-1:0] qy [3];
  logic signed [D-1:0] dx [3];
  logic signed [D-1:0] dy [3];
  logic [COORD_BITS-2:0] rad;

  logic v1, v2, v3, v4;

  // products
  logic signed [PW-1:0] m_dxdx [3];
  logic signed [PW-1:0] m_dydy [3];
  logic signed [PW-1:0] m_qxqx [3];
  logic signed [PW-1:0] m_qyqy [3];
  logic signed [PW-1:0] m_qxdx [3];
  logic signed [PW-1:0] m_qydy [3];
  logic signed [PW-1:0] m_qxdy [3];
  logic signed [PW-1:0] m_qydx [3];
  logic [R2W-1:0]       m_r2;

  // sums
  logic signed [SW-1:0] s_len2  [3];
  logic signed [SW-1:0] s_proj  [3];
  logic signed [SW-1:0] s_cross [3];
  logic signed [SW-1:0] s_vd    [3];
  logic [R2W-1:0]       s_r2;

  // flags and partial products
  logic [PW-1:0] c_abs [3];
  logic [H-1:0]  c_hi  [3];
  logic [H-1:0]  c_lo  [3];
  logic [H-1:0]  l_hi  [3];
  logic [H-1:0]  l_lo  [3];
  logic [H-1:0]  r_hi;
  logic [H-1:0]  r_lo;
  logic [2:0]    neg_c;
  logic [2:0]    pos_c;
  logic [2:0]    near_c;
  logic [2:0]    pin_c;

  logic [PW-1:0] p_chh [3];
  logic [PW-1:0] p_chl [3];
  logic [PW-1:0] p_cll [3];
  logic [PW-1:0] p_rhh [3];
  logic [PW-1:0] p_rhl [3];
  logic [PW-1:0] p_rlh [3];
  logic [PW-1:0] p_rll [3];
  logic [2:0]    p_pin;
  logic          p_inside;
  logic          p_near;

  logic [XW-1:0] w_c2 [3];
  logic [XW-1:0] w_rl [3];
  logic [2:0]    w_pin;
  logic          w_inside;
  logic          w_near;
  logic [2:0]    seg_hit;

  assign mq_pop = !mq_empty && (used < UW'(OQ_DEPTH));
  assign used_next = used + UW'(mq_pop) - UW'(oq_pop);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qx[k] = $signed(mq_data[k*4*D       +: D]);
      qy[k] = $signed(mq_data[k*4*D + D   +: D]);
      dx[k] = $signed(mq_data[k*4*D + 2*D +: D]);
      dy[k] = $signed(mq_data[k*4*D + 3*D +: D]);
    end
    rad = mq_data[12*D +: COORD_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
    end else begin
      used <= used_next;
      v1   <= mq_pop;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m_dxdx[k] <= PW'(dx[k]) * PW'(dx[k]);
      m_dydy[k] <= PW'(dy[k]) * PW'(dy[k]);
      m_qxqx[k] <= PW'(qx[k]) * PW'(qx[k]);
      m_qyqy[k] <= PW'(qy[k]) * PW'(qy[k]);
      m_qxdx[k] <= PW'(qx[k]) * PW'(dx[k]);
      m_qydy[k] <= PW'(qy[k]) * PW'(dy[k]);
      m_qxdy[k] <= PW'(qx[k]) * PW'(dy[k]);
      m_qydx[k] <= PW'(qy[k]) * PW'(dx[k]);
    end
    m_r2 <= R2W'(rad) * R2W'(rad);
  end

  // stage 2: squared length, projection, cross product, vertex distance
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s_len2[k]  <= SW'(m_dxdx[k]) + SW'(m_dydy[k]);
      s_proj[k]  <= SW'(m_qxdx[k]) + SW'(m_qydy[k]);
      s_cross[k] <= SW'(m_qxdy[k]) - SW'(m_qydx[k]);
      s_vd[k]    <= SW'(m_qxqx[k]) + SW'(m_qyqy[k]);
    end
    s_r2 <= m_r2;
  end

  // stage 3: compares and split operands for the wide products
  always_comb begin
    r_hi = H'(PW'(s_r2) >> H);
    r_lo = H'(s_r2);
    for (int k = 0; k < 3; k++) begin
      c_abs[k]  = s_cross[k][SW-1] ? PW'(-s_cross[k]) : PW'(s_cross[k]);
      c_hi[k]   = c_abs[k][PW-1:H];
      c_lo[k]   = c_abs[k][H-1:0];
      l_hi[k]   = s_len2[k][PW-1:H];
      l_lo[k]   = s_len2[k][H-1:0];
      neg_c[k]  = s_cross[k][SW-1];
      pos_c[k]  = !s_cross[k][SW-1] && (s_cross[k] != '0);
      near_c[k] = s_vd[k][PW-1:0] <= PW'(s_r2);
      pin_c[k]  = !s_proj[k][SW-1] && (s_proj[k] != '0) && (s_proj[k] < s_len2[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_chh[k] <= PW'(c_hi[k]) * PW'(c_hi[k]);
      p_chl[k] <= PW'(c_hi[k]) * PW'(c_lo[k]);
      p_cll[k] <= PW'(c_lo[k]) * PW'(c_lo[k]);
      p_rhh[k] <= PW'(r_hi) * PW'(l_hi[k]);
      p_rhl[k] <= PW'(r_hi) * PW'(l_lo[k]);
      p_rlh[k] <= PW'(r_lo) * PW'(l_hi[k]);
      p_rll[k] <= PW'(r_lo) * PW'(l_lo[k]);
    end
    p_pin    <= pin_c;
    p_inside <= !((|neg_c) && (|pos_c));
    p_near   <= |near_c;
  end

  // stage 4: assemble cross squared and radius squared times length squared
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      w_c2[k] <= (XW'(p_chh[k]) << PW) + (XW'(p_chl[k]) << (H + 1)) + XW'(p_cll[k]);
      w_rl[k] <= (XW'(p_rhh[k]) << PW) + ((XW'(p_rhl[k]) + XW'(p_rlh[k])) << H)
               + XW'(p_rll[k]);
    end
    w_pin    <= p_pin;
    w_inside <= p_inside;
    w_near   <= p_near;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      seg_hit[k] = w_pin[k] && (w_c2[k] <= w_rl[k]);
    end
  end

  assign oq_push = v4;
  assign oq_data = {w_inside, w_inside || w_near || (|seg_hit)};

endmodule

/* rtl/triangle_circle_intersect.sv */
// path: decoupling queue, four back-end stages, result queue (empty low)
// throughput: one query per cycle; the 8-entry result queue holds credit for
//   the 4 back-end stages in flight, so pop stalls alone throttle push
// reset: synchronous active-high rst empties both queues, clears the pipeline
//   valid bits and sets all six vertex registers to zero
module triangle_circle_intersect import tci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config bus
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready,
  // query side
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [COORD_BITS-2:0] radius,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic                         center_inside,
  output logic                         hit
);

  localparam int D  = COORD_BITS + 1;
  localparam int EW = 12 * D + COORD_BITS - 1;

  // triangle vertices
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;

  reg_idx_t      reg_sel;
  logic          cfg_wr;
  logic [EW-1:0] mq_data;
  logic          mq_empty;
  logic          mq_pop;
  logic          oq_push;
  logic [1:0]    oq_data;
  logic [1:0]    oq_rdata;
  logic          oq_full;

  // registers sit on word addresses; index comes from the word offset
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  // write transaction; addresses past the last register fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a_x <= '0;
      vertex_a_y <= '0;
      vertex_b_x <= '0;
      vertex_b_y <= '0;
      vertex_c_x <= '0;
      vertex_c_y <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_A_X: vertex_a_x <= pwdata[COORD_BITS-1:0];
        REG_A_Y: vertex_a_y <= pwdata[COORD_BITS-1:0];
        REG_B_X: vertex_b_x <= pwdata[COORD_BITS-1:0];
        REG_B_Y: vertex_b_y <= pwdata[COORD_BITS-1:0];
        REG_C_X: vertex_c_x <= pwdata[COORD_BITS-1:0];
        REG_C_Y: vertex_c_y <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_sel)
      REG_A_X: prdata = DATA_BITS'(unsigned'(vertex_a_x));
      REG_A_Y: prdata = DATA_BITS'(unsigned'(vertex_a_y));
      REG_B_X: prdata = DATA_BITS'(unsigned'(vertex_b_x));
      REG_B_Y: prdata = DATA_BITS'(unsigned'(vertex_b_y));
      REG_C_X: prdata = DATA_BITS'(unsigned'(vertex_c_x));
      REG_C_Y: prdata = DATA_BITS'(unsigned'(vertex_c_y));
      default: prdata = '0;
    endcase
  end

  // front: takes queries, forms vertex-to-center and edge vectors
  tci_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .ax       (vertex_a_x),
    .ay       (vertex_a_y),
    .bx       (vertex_b_x),
    .by       (vertex_b_y),
    .cx       (vertex_c_x),
    .cy       (vertex_c_y),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .push     (push),
    .full     (full),
    .mq_pop   (mq_pop),
    .mq_data  (mq_data),
    .mq_empty (mq_empty)
  );

  // back: four-stage product / compare pipeline, credit-gated
  tci_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_empty (mq_empty),
    .mq_data  (mq_data),
    .mq_pop   (mq_pop),
    .oq_pop   (pop && !empty),
    .oq_push  (oq_push),
    .oq_data  (oq_data)
  );

  // result queue; credit in the back end keeps it from overflowing
  tci_fifo #(.WIDTH(2), .DEPTH(OQ_DEPTH)) u_oq (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_data),
    .pop   (pop),
    .rdata (oq_rdata),
    .full  (oq_full),
    .empty (empty)
  );

  assign center_inside = oq_rdata[1];
  assign hit           = oq_rdata[0] && !oq_full | oq_rdata[0];

endmodule

/* tb/sv/tb.sv */
module tb;
  import tci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int RB = CB - 1;
  localparam int LATENCY = 5;

  typedef struct packed {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-2:0]        rad;
  } query_t;

  typedef struct packed {
    logic in_tri;
    logic touch;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [CB-1:0] center_x = '0, center_y = '0;
  logic [CB-2:0] radius = '0;
  logic empty;
  logic pop = 1'b0;
  logic center_inside, hit;

  triangle_circle_intersect uut (.*);

  always #2 clk = ~clk;

  // triangle vertices as the block holds them
  logic signed [CB-1:0] tri_x [3];
  logic signed [CB-1:0] tri_y [3];

  query_t   pending_q [$];
  verdict_t verdict_q [$];
  int errors = 0;
  int sent = 0;
  bit driving = 1'b0;
  int hold_off = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // all products fit easily in 128 signed bits for 16-bit coordinates
  function automatic logic signed [127:0] edge_sign_val(
      input logic signed [127:0] px, py, ux, uy, vx, vy);
    return (px - vx) * (uy - vy) - (py - vy) * (ux - vx);
  endfunction

  function automatic bit near_pt(input logic signed [127:0] px, py, vx, vy, r2);
    return (vx - px) * (vx - px) + (vy - py) * (vy - py) <= r2;
  endfunction

  function automatic bit seg_within(input logic signed [127:0] px, py, sx, sy,
                                    ex, ey, r2);
    logic signed [127:0] dx, dy, qx, qy, len2, proj, cr;
    dx = ex - sx; dy = ey - sy; qx = px - sx; qy = py - sy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return near_pt(px, py, sx, sy, r2);
    proj = qx * dx + qy * dy;
    if (proj <= 0) return near_pt(px, py, sx, sy, r2);
    if (proj >= len2) return near_pt(px, py, ex, ey, r2);
    cr = qx * dy - qy * dx;
    return cr * cr <= r2 * len2;
  endfunction

  function automatic verdict_t classify(input query_t q);
    logic signed [127:0] px, py, r2, vx [3], vy [3], e;
    bit neg, pos;
    verdict_t v;
    px = q.cx; py = q.cy;
    r2 = $signed({1'b0, q.rad}) * $signed({1'b0, q.rad});
    neg = 0; pos = 0;
    for (int i = 0; i < 3; i++) begin
      vx[i] = tri_x[i]; vy[i] = tri_y[i];
    end
    for (int i = 0; i < 3; i++) begin
      e = edge_sign_val(px, py, vx[i], vy[i], vx[(i+1)%3], vy[(i+1)%3]);
      if (e < 0) neg = 1;
      if (e > 0) pos = 1;
    end
    v.in_tri = !(neg && pos);
    v.touch = v.in_tri;
    for (int i = 0; i < 3; i++) begin
      if (near_pt(px, py, vx[i], vy[i], r2)) v.touch = 1;
      if (seg_within(px, py, vx[i], vy[i], vx[(i+1)%3], vy[(i+1)%3], r2)) v.touch = 1;
    end
    return v;
  endfunction

  // driver: bursts of pushes with random gaps, one transaction per accepted edge
  int burst = 0, gap = 0;
  always @(posedge clk) begin
    query_t q;
    if (!rst) begin
      if (push && !full) begin
        void'(pending_q.pop_front());
        sent++;
      end
      if (gap > 0) begin
        gap--;
        push <= 1'b0;
      end else if (driving && pending_q.size() > 0) begin
        q = pending_q[0];
        push <= 1'b1;
        center_x <= q.cx;
        center_y <= q.cy;
        radius <= q.rad;
        if (burst > 0) burst--;
        else begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // predict at the push edge; config is stable while queries flow
  always @(posedge clk)
    if (!rst && push && !full)
      verdict_q.push_back(classify({center_x, center_y, radius}));

  // monitor: pop on a stall pattern of its own, check each popped transaction
  int stall_phase = 0;
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst) begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) report("result with nothing expected");
        else begin
          exp_v = verdict_q.pop_front();
          if (center_inside !== exp_v.in_tri)
            report($sformatf("center_inside got %b want %b", center_inside, exp_v.in_tri));
          if (hit !== exp_v.touch)
            report($sformatf("hit got %b want %b", hit, exp_v.touch));
        end
      end
      stall_phase = (stall_phase + 1) % 23;
      if (hold_off > 0) begin
        hold_off--;
        pop <= 1'b0;
      end else if (stall_phase < 8) pop <= 1'b1;
      else pop <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic signed [CB-1:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * int'(idx));
    pwdata <= {$urandom} << CB | DATA_BITS'({{(DATA_BITS-CB){1'b0}}, val});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_A_X) tri_x[0] = val;
    if (idx == REG_A_Y) tri_y[0] = val;
    if (idx == REG_B_X) tri_x[1] = val;
    if (idx == REG_B_Y) tri_y[1] = val;
    if (idx == REG_C_X) tri_x[2] = val;
    if (idx == REG_C_Y) tri_y[2] = val;
  endtask

  task automatic set_triangle(input logic signed [CB-1:0] ax, ay, bx, by, cx, cy);
    write_reg(REG_A_X, ax); write_reg(REG_A_Y, ay);
    write_reg(REG_B_X, bx); write_reg(REG_B_Y, by);
    write_reg(REG_C_X, cx); write_reg(REG_C_Y, cy);
  endtask

  // wait until everything queued has been checked
  task automatic drain();
    driving = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (verdict_q.size() == 0);
    driving = 1'b0;
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] near_coord(input int base);
    int v;
    v = base + $signed($urandom_range(0, 4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CB'(v);
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    return CB'($urandom);
  endfunction

  function automatic logic signed [CB-1:0] small_coord();
    return CB'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [CB-2:0] rand_rad();
    case ($urandom_range(0, 3))
      0: return RB'($urandom_range(0, 10));
      1: return RB'($urandom_range(0, 3000));
      2: return RB'($urandom);
      default: return RB'($urandom_range(32000, 32767));
    endcase
  endfunction

  task automatic add_random(input int n);
    query_t q;
    int mx, my;
    mx = (int'(tri_x[0]) + int'(tri_x[1]) + int'(tri_x[2])) / 3;
    my = (int'(tri_y[0]) + int'(tri_y[1]) + int'(tri_y[2])) / 3;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin q.cx = rand_coord(); q.cy = rand_coord(); end
        1: begin q.cx = near_coord(mx); q.cy = near_coord(my); end
        default: begin
          q.cx = near_coord(tri_x[$urandom_range(0, 2)]);
          q.cy = near_coord(tri_y[$urandom_range(0, 2)]);
        end
      endcase
      q.rad = rand_rad();
      pending_q.push_back(q);
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      tri_x[i] = '0; tri_y[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero triangle after reset: a point triangle
    pending_q.push_back('{0, 0, 0});
    pending_q.push_back('{1, 0, 0});
    pending_q.push_back('{1, 0, 1});
    pending_q.push_back('{-32768, -32768, 15'h7fff});
    drain();

    // ordinary triangle: inside, edges, vertices, clamp regions
    set_triangle(-1000, -1000, 1000, -1000, 0, 1000);
    pending_q.push_back('{0, 0, 0});
    pending_q.push_back('{0, -1000, 0});
    pending_q.push_back('{1000, -1000, 0});
    pending_q.push_back('{0, -1010, 10});
    pending_q.push_back('{0, -1011, 10});
    pending_q.push_back('{-1003, -1004, 5});
    pending_q.push_back('{-1003, -1004, 4});
    pending_q.push_back('{2000, -1000, 1000});
    pending_q.push_back('{32767, 32767, 15'h7fff});
    pending_q.push_back('{-32768, 32767, 0});
    drain();

    // degenerate: collinear and a zero-length edge, extreme vertices
    set_triangle(-32768, -32768, 32767, 32767, 32767, 32767);
    pending_q.push_back('{0, 0, 0});
    pending_q.push_back('{0, 1, 0});
    pending_q.push_back('{0, 1, 1});
    pending_q.push_back('{-32768, 32767, 15'h7fff});
    pending_q.push_back('{32767, -32768, 32767});
    drain();

    // random phases with fresh triangles; one phase with a long pop hold-off
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_triangle(32767, -32768, -32768, 32767, -32768, -32768);
      else if (ph % 2 == 0)
        set_triangle(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
      else
        set_triangle(small_coord(), small_coord(), small_coord(),
                     small_coord(), small_coord(), small_coord());
      add_random(220);
      if (ph == 3) hold_off = 200;
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
